// File: design/esd_pkg.sv
`timescale 1ns / 1ps

package esd_pkg;

    localparam int MAX_TOKEN_LEN = 1024;
    localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int CH_W          = 8;
    localparam int LEN_W         = 11;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = Q_PTR_W + 1;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_SEVEN  = 8'h37;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_B   = 8'h62;
    localparam logic [CH_W-1:0] CH_LC_F   = 8'h66;
    localparam logic [CH_W-1:0] CH_LC_N   = 8'h6E;
    localparam logic [CH_W-1:0] CH_LC_R   = 8'h72;
    localparam logic [CH_W-1:0] CH_LC_T   = 8'h74;
    localparam logic [CH_W-1:0] CH_LC_X   = 8'h78;
    localparam logic [CH_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UC_F   = 8'h46;

    localparam logic [CH_W-1:0] CODE_BEL = 8'h07;
    localparam logic [CH_W-1:0] CODE_BS  = 8'h08;
    localparam logic [CH_W-1:0] CODE_HT  = 8'h09;
    localparam logic [CH_W-1:0] CODE_LF  = 8'h0A;
    localparam logic [CH_W-1:0] CODE_FF  = 8'h0C;
    localparam logic [CH_W-1:0] CODE_CR  = 8'h0D;

    // hex letter offsets: value = ch - offset
    localparam logic [CH_W-1:0] LC_HEX_OFS = 8'h57;
    localparam logic [CH_W-1:0] UC_HEX_OFS = 8'h37;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            is_end;
        logic            is_bslash;
        logic            is_oct;
        logic            is_x;
        logic            is_hex;
        logic [3:0]      hex_val;
        logic [CH_W-1:0] esc_byte;
    } t_class;

    typedef struct packed {
        t_kind            kind;
        logic [CH_W-1:0]  out_byte;
        logic [LEN_W-1:0] token_length;
        logic             last;
    } t_result;

endpackage

// File: design/esd_front.sv
`timescale 1ns / 1ps

module esd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    input  logic [esd_pkg::CH_W-1:0]    i_ch,
    output logic                        full,
    output logic                        o_valid,
    output esd_pkg::t_class             o_item,
    input  logic                        i_take
);

    esd_pkg::t_class                r_mem [esd_pkg::Q_DEPTH];
    logic [esd_pkg::Q_PTR_W-1:0]    r_wr;
    logic [esd_pkg::Q_PTR_W-1:0]    r_rd;
    logic [esd_pkg::Q_CNT_W-1:0]    r_cnt;
    logic [esd_pkg::Q_CNT_W-1:0]    n_cnt;
    esd_pkg::t_class                cls;
    logic                           wr_fire;
    logic                           rd_fire;

    // classify the raw character
    always_comb begin
        cls          = '0;
        cls.ch       = i_ch;
        cls.is_end   = (i_ch == esd_pkg::CH_NUL) || (i_ch == esd_pkg::CH_SPACE) ||
                       ((i_ch >= esd_pkg::CH_TAB) && (i_ch <= esd_pkg::CH_CR));
        cls.is_bslash = (i_ch == esd_pkg::CH_BSLASH);
        cls.is_oct   = (i_ch >= esd_pkg::CH_ZERO) && (i_ch <= esd_pkg::CH_SEVEN);
        cls.is_x     = (i_ch == esd_pkg::CH_LC_X);
        if ((i_ch >= esd_pkg::CH_ZERO) && (i_ch <= esd_pkg::CH_NINE)) begin
            cls.is_hex  = 1'b1;
            cls.hex_val = i_ch[3:0];
        end else if ((i_ch >= esd_pkg::CH_LC_A) && (i_ch <= esd_pkg::CH_LC_F)) begin
            cls.is_hex  = 1'b1;
            cls.hex_val = 4'(i_ch - esd_pkg::LC_HEX_OFS);
        end else if ((i_ch >= esd_pkg::CH_UC_A) && (i_ch <= esd_pkg::CH_UC_F)) begin
            cls.is_hex  = 1'b1;
            cls.hex_val = 4'(i_ch - esd_pkg::UC_HEX_OFS);
        end
        unique case (i_ch)
            esd_pkg::CH_LC_A: cls.esc_byte = esd_pkg::CODE_BEL;
            esd_pkg::CH_LC_B: cls.esc_byte = esd_pkg::CODE_BS;
            esd_pkg::CH_LC_T: cls.esc_byte = esd_pkg::CODE_HT;
            esd_pkg::CH_LC_F: cls.esc_byte = esd_pkg::CODE_FF;
            esd_pkg::CH_LC_N: cls.esc_byte = esd_pkg::CODE_LF;
            esd_pkg::CH_LC_R: cls.esc_byte = esd_pkg::CODE_CR;
            default:          cls.esc_byte = i_ch;
        endcase
    end

    assign full    = (r_cnt == esd_pkg::Q_CNT_W'(esd_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign wr_fire = push && !full;
    assign rd_fire = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (wr_fire && !rd_fire) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_fire) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_fire) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr] <= cls;
        end
    end

endmodule

// File: design/esd_back.sv
`timescale 1ns / 1ps

module esd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  esd_pkg::t_class     i_item,
    output logic                o_take,
    output logic                empty,
    input  logic                pop,
    output esd_pkg::t_result    o_result
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ESC  = 4'b0010,
        PH_OCT  = 4'b0100,
        PH_HEX  = 4'b1000
    } t_phase;

    t_phase                         r_phase;
    t_phase                         n_phase;
    logic [1:0]                     r_dcnt;
    logic [1:0]                     n_dcnt;
    logic [8:0]                     r_pend;
    logic [8:0]                     n_pend;
    logic [esd_pkg::CNT_W-1:0]      r_count;
    logic [esd_pkg::CNT_W-1:0]      n_count;

    esd_pkg::t_result               r_mem [esd_pkg::Q_DEPTH];
    logic [esd_pkg::Q_PTR_W-1:0]    r_wr;
    logic [esd_pkg::Q_PTR_W-1:0]    r_rd;
    logic [esd_pkg::Q_CNT_W-1:0]    r_ocnt;

    esd_pkg::t_result               res_a;
    esd_pkg::t_result               res_b;
    esd_pkg::t_result               res0;
    esd_pkg::t_result               res1;
    logic                           a_vld;
    logic                           b_vld;
    logic                           do_idle;
    logic [8:0]                     oct_next;
    logic [1:0]                     nres;
    logic                           pop_fire;

    function automatic logic [esd_pkg::CNT_W-1:0] sat_inc(
        input logic [esd_pkg::CNT_W-1:0] cnt
    );
        if (cnt < esd_pkg::CNT_W'(esd_pkg::MAX_TOKEN_LEN)) begin
            return cnt + 1'b1;
        end
        return cnt;
    endfunction

    function automatic esd_pkg::t_result mk_byte(input logic [esd_pkg::CH_W-1:0] b);
        esd_pkg::t_result r;
        r          = '0;
        r.kind     = esd_pkg::KIND_BYTE;
        r.out_byte = b;
        return r;
    endfunction

    assign o_take   = i_valid && (r_ocnt <= esd_pkg::Q_CNT_W'(esd_pkg::Q_DEPTH - 2));
    assign oct_next = {r_pend[5:0], i_item.ch[2:0]};

    always_comb begin
        n_phase = r_phase;
        n_dcnt  = r_dcnt;
        n_pend  = r_pend;
        n_count = r_count;
        a_vld   = 1'b0;
        b_vld   = 1'b0;
        res_a   = '0;
        res_b   = '0;
        do_idle = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                do_idle = 1'b1;
            end
            PH_ESC: begin
                if (i_item.ch == esd_pkg::CH_NUL) begin
                    a_vld      = 1'b1;
                    res_a.kind = esd_pkg::KIND_ERR;
                    n_count    = '0;
                    n_phase    = PH_IDLE;
                    n_dcnt     = '0;
                    n_pend     = '0;
                end else if (i_item.is_oct) begin
                    n_phase = PH_OCT;
                    n_pend  = {6'd0, i_item.ch[2:0]};
                    n_dcnt  = 2'd1;
                end else if (i_item.is_x) begin
                    n_phase = PH_HEX;
                    n_pend  = '0;
                    n_dcnt  = '0;
                end else begin
                    n_phase = PH_IDLE;
                    n_dcnt  = '0;
                    n_pend  = '0;
                    a_vld   = 1'b1;
                    res_a   = mk_byte(i_item.esc_byte);
                    n_count = sat_inc(r_count);
                end
            end
            PH_OCT: begin
                if (i_item.is_oct) begin
                    if (r_dcnt >= 2'd2) begin
                        n_phase = PH_IDLE;
                        n_dcnt  = '0;
                        n_pend  = '0;
                        a_vld   = 1'b1;
                        res_a   = mk_byte(oct_next[7:0]);
                        n_count = sat_inc(r_count);
                    end else begin
                        n_pend = oct_next;
                        n_dcnt = r_dcnt + 1'b1;
                    end
                end else begin
                    n_phase = PH_IDLE;
                    n_dcnt  = '0;
                    n_pend  = '0;
                    a_vld   = 1'b1;
                    res_a   = mk_byte(r_pend[7:0]);
                    n_count = sat_inc(r_count);
                    do_idle = 1'b1;
                end
            end
            PH_HEX: begin
                if (i_item.is_hex) begin
                    if (r_dcnt == '0) begin
                        n_pend = {5'd0, i_item.hex_val};
                        n_dcnt = 2'd1;
                    end else begin
                        n_phase = PH_IDLE;
                        n_dcnt  = '0;
                        n_pend  = '0;
                        a_vld   = 1'b1;
                        res_a   = mk_byte({r_pend[3:0], i_item.hex_val});
                        n_count = sat_inc(r_count);
                    end
                end else if (r_dcnt == '0) begin
                    a_vld      = 1'b1;
                    res_a.kind = esd_pkg::KIND_ERR;
                    n_count    = '0;
                    n_phase    = PH_IDLE;
                    n_dcnt     = '0;
                    n_pend     = '0;
                end else begin
                    n_phase = PH_IDLE;
                    n_dcnt  = '0;
                    n_pend  = '0;
                    a_vld   = 1'b1;
                    res_a   = mk_byte(r_pend[7:0]);
                    n_count = sat_inc(r_count);
                    do_idle = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_dcnt  = '0;
                n_pend  = '0;
            end
        endcase

        // plain character handling, also after a cut-short digit run
        if (do_idle) begin
            if (i_item.is_end) begin
                b_vld              = 1'b1;
                res_b.kind         = esd_pkg::KIND_END;
                res_b.token_length = esd_pkg::LEN_W'(n_count);
                n_count            = '0;
                n_phase            = PH_IDLE;
                n_dcnt             = '0;
                n_pend             = '0;
            end else if (i_item.is_bslash) begin
                n_phase = PH_ESC;
            end else begin
                b_vld   = 1'b1;
                res_b   = mk_byte(i_item.ch);
                n_count = sat_inc(n_count);
            end
        end

        res0 = a_vld ? res_a : res_b;
        res1 = res_b;
        nres = 2'(a_vld) + 2'(b_vld);
        res0.last = (nres == 2'd1);
        res1.last = 1'b1;
    end

    assign empty    = (r_ocnt == '0);
    assign o_result = r_mem[r_rd];
    assign pop_fire = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dcnt  <= '0;
            r_pend  <= '0;
            r_count <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_ocnt  <= '0;
        end else begin
            if (o_take) begin
                r_phase <= n_phase;
                r_dcnt  <= n_dcnt;
                r_pend  <= n_pend;
                r_count <= n_count;
                r_wr    <= r_wr + esd_pkg::Q_PTR_W'(nres);
            end
            if (pop_fire) begin
                r_rd <= r_rd + 1'b1;
            end
            r_ocnt <= r_ocnt + (o_take ? esd_pkg::Q_CNT_W'(nres) : '0)
                      - esd_pkg::Q_CNT_W'(pop_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && (nres != '0)) begin
            r_mem[r_wr] <= res0;
        end
        if (o_take && (nres == 2'd2)) begin
            r_mem[esd_pkg::Q_PTR_W'(r_wr + 1'b1)] <= res1;
        end
    end

endmodule

// File: design/escape_sequence_decoder.sv
`timescale 1ns / 1ps

// Streaming decoder for backslash-escaped tokens, one character per transaction.
// Each character yields zero, one or two results (decoded byte, token finished
// with its saturating length, or malformed escape error); last marks the final
// result of a character. A new character is taken every cycle while full is low;
// each result passes through the front character queue and then the back result
// queue before it reaches the output. The sustained rate is one character per cycle,
// bounded by the result side, which delivers one result per pop; the back end
// waits while the result queue holds more than two entries, so characters that
// give two results can stall the input.
module escape_sequence_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [esd_pkg::CH_W-1:0]        i_ch,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      o_kind,
    output logic [esd_pkg::CH_W-1:0]        o_out_byte,
    output logic [esd_pkg::LEN_W-1:0]       o_token_length,
    output logic                            o_last
);

    logic               mid_valid;
    logic               mid_take;
    esd_pkg::t_class    mid_item;
    esd_pkg::t_result   res;

    esd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_ch    (i_ch),
        .full    (full),
        .o_valid (mid_valid),
        .o_item  (mid_item),
        .i_take  (mid_take)
    );

    esd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mid_valid),
        .i_item   (mid_item),
        .o_take   (mid_take),
        .empty    (empty),
        .pop      (pop),
        .o_result (res)
    );

    assign o_kind         = res.kind;
    assign o_out_byte     = res.out_byte;
    assign o_token_length = res.token_length;
    assign o_last         = res.last;

endmodule

// File: tb/tb_escape_sequence_decoder.sv
`timescale 1ns / 1ps

module tb_escape_sequence_decoder;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 440;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ESC  = 4'b0010,
        PH_OCT  = 4'b0100,
        PH_HEX  = 4'b1000
    } t_phase;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic [esd_pkg::CH_W-1:0]  i_ch;
    logic                      empty;
    logic                      pop;
    logic [1:0]                o_kind;
    logic [esd_pkg::CH_W-1:0]  o_out_byte;
    logic [esd_pkg::LEN_W-1:0] o_token_length;
    logic                      o_last;

    // decoder state mirrored by the testbench
    t_phase                    dec_phase;
    logic [1:0]                dec_digits;
    logic [8:0]                dec_value;
    logic [esd_pkg::LEN_W-1:0] dec_len;

    esd_pkg::t_result          step_out[$];
    esd_pkg::t_result          pending_results[$];

    int               n_fail      = 0;
    int               n_sent      = 0;
    int               cycle_count = 0;
    bit               sender_gaps = 1'b1;
    bit               hold_req    = 1'b0;
    bit               holding     = 1'b0;

    logic [esd_pkg::CH_W-1:0] esc_letters[6] = '{
        esd_pkg::CH_LC_A, esd_pkg::CH_LC_B, esd_pkg::CH_LC_T,
        esd_pkg::CH_LC_F, esd_pkg::CH_LC_N, esd_pkg::CH_LC_R
    };

    escape_sequence_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_ch           (i_ch),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_token_length (o_token_length),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic bit is_blank(input logic [esd_pkg::CH_W-1:0] c);
        return (c == esd_pkg::CH_SPACE) || (c >= esd_pkg::CH_TAB && c <= esd_pkg::CH_CR);
    endfunction

    function automatic bit is_oct(input logic [esd_pkg::CH_W-1:0] c);
        return (c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_SEVEN);
    endfunction

    function automatic int hex_val(input logic [esd_pkg::CH_W-1:0] c);
        if (c >= esd_pkg::CH_ZERO && c <= esd_pkg::CH_NINE)
            return int'(c - esd_pkg::CH_ZERO);
        if (c >= esd_pkg::CH_LC_A && c <= esd_pkg::CH_LC_F)
            return int'(c - esd_pkg::CH_LC_A) + 10;
        if (c >= esd_pkg::CH_UC_A && c <= esd_pkg::CH_UC_F)
            return int'(c - esd_pkg::CH_UC_A) + 10;
        return -1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [esd_pkg::CH_W-1:0] rand_plain();
        logic [esd_pkg::CH_W-1:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == esd_pkg::CH_BSLASH || is_blank(c))
            c = esd_pkg::CH_UC_A + 8'($urandom_range(0, 25));
        return c;
    endfunction

    function automatic logic [esd_pkg::CH_W-1:0] rand_blank();
        if ($urandom_range(0, 5) == 0)
            return esd_pkg::CH_SPACE;
        return esd_pkg::CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    // ---------------- prediction ----------------

    task automatic add_result(input esd_pkg::t_kind k, input logic [esd_pkg::CH_W-1:0] b,
                              input logic [esd_pkg::LEN_W-1:0] len);
        esd_pkg::t_result r;
        r.kind         = k;
        r.out_byte     = b;
        r.token_length = len;
        r.last         = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic reset_run();
        dec_phase  = PH_IDLE;
        dec_digits = '0;
        dec_value  = '0;
    endtask

    task automatic add_byte(input logic [esd_pkg::CH_W-1:0] b);
        if (dec_len < esd_pkg::MAX_TOKEN_LEN)
            dec_len++;
        add_result(esd_pkg::KIND_BYTE, b, '0);
    endtask

    task automatic add_error();
        add_result(esd_pkg::KIND_ERR, '0, '0);
        dec_len = '0;
        reset_run();
    endtask

    task automatic plain_char(input logic [esd_pkg::CH_W-1:0] c);
        if (c == esd_pkg::CH_NUL || is_blank(c)) begin
            add_result(esd_pkg::KIND_END, '0, dec_len);
            dec_len = '0;
            reset_run();
        end else if (c == esd_pkg::CH_BSLASH) begin
            dec_phase = PH_ESC;
        end else begin
            add_byte(c);
        end
    endtask

    task automatic decode_char(input logic [esd_pkg::CH_W-1:0] c);
        logic [esd_pkg::CH_W-1:0] v;
        int                       hv;
        step_out.delete();
        case (dec_phase)
            PH_IDLE: begin
                plain_char(c);
            end
            PH_ESC: begin
                if (c == esd_pkg::CH_NUL) begin
                    add_error();
                end else if (is_oct(c)) begin
                    dec_phase  = PH_OCT;
                    dec_value  = {1'b0, c - esd_pkg::CH_ZERO};
                    dec_digits = 2'd1;
                end else if (c == esd_pkg::CH_LC_X) begin
                    dec_phase  = PH_HEX;
                    dec_value  = '0;
                    dec_digits = '0;
                end else begin
                    case (c)
                        esd_pkg::CH_LC_A: v = esd_pkg::CODE_BEL;
                        esd_pkg::CH_LC_B: v = esd_pkg::CODE_BS;
                        esd_pkg::CH_LC_T: v = esd_pkg::CODE_HT;
                        esd_pkg::CH_LC_F: v = esd_pkg::CODE_FF;
                        esd_pkg::CH_LC_N: v = esd_pkg::CODE_LF;
                        esd_pkg::CH_LC_R: v = esd_pkg::CODE_CR;
                        default:          v = c;
                    endcase
                    reset_run();
                    add_byte(v);
                end
            end
            PH_OCT: begin
                if (is_oct(c)) begin
                    dec_value  = {dec_value[5:0], c[2:0]};
                    dec_digits = dec_digits + 2'd1;
                    if (dec_digits == 2'd3) begin
                        v = dec_value[7:0];
                        reset_run();
                        add_byte(v);
                    end
                end else begin
                    v = dec_value[7:0];
                    reset_run();
                    add_byte(v);
                    plain_char(c);
                end
            end
            default: begin
                hv = hex_val(c);
                if (hv >= 0) begin
                    if (dec_digits == 2'd0) begin
                        dec_value  = 9'(hv);
                        dec_digits = 2'd1;
                    end else begin
                        v = {dec_value[3:0], 4'(hv)};
                        reset_run();
                        add_byte(v);
                    end
                end else if (dec_digits == 2'd0) begin
                    add_error();
                end else begin
                    v = dec_value[7:0];
                    reset_run();
                    add_byte(v);
                    plain_char(c);
                end
            end
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            pending_results.push_back(step_out[i]);
    endtask

    // ---------------- stimulus ----------------

    task automatic send_char(input logic [esd_pkg::CH_W-1:0] c);
        int gap;
        push <= 1'b1;
        i_ch <= c;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        decode_char(c);
        n_sent++;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            i_ch <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_segment();
        int                       k;
        int                       hv;
        logic [esd_pkg::CH_W-1:0] c;
        k = $urandom_range(0, 19);
        case (k)
            0, 1, 2, 3, 4, 5: begin
                send_char(rand_plain());
            end
            6, 7: begin
                send_char(esd_pkg::CH_BSLASH);
                send_char(esc_letters[$urandom_range(0, 5)]);
            end
            8, 9: begin
                send_char(esd_pkg::CH_BSLASH);
                repeat ($urandom_range(1, 3))
                    send_char(esd_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
            end
            10, 11, 19: begin
                send_char(esd_pkg::CH_BSLASH);
                send_char(esd_pkg::CH_LC_X);
                repeat ($urandom_range(1, 2)) begin
                    hv = $urandom_range(0, 15);
                    if (hv < 10)
                        c = esd_pkg::CH_ZERO + 8'(hv);
                    else if ($urandom_range(0, 1) == 0)
                        c = esd_pkg::CH_LC_A + 8'(hv - 10);
                    else
                        c = esd_pkg::CH_UC_A + 8'(hv - 10);
                    send_char(c);
                end
            end
            12: begin
                send_char(esd_pkg::CH_BSLASH);
                send_char(8'($urandom_range(1, 255)));
            end
            13: begin
                send_char(esd_pkg::CH_BSLASH);
                send_char(rand_blank());
            end
            14, 15, 16: begin
                send_char(8'($urandom));
            end
            17: begin
                send_char(esd_pkg::CH_BSLASH);
                send_char(esd_pkg::CH_NUL);
            end
            default: begin
                c = 8'($urandom);
                if (hex_val(c) >= 0)
                    c = esd_pkg::CH_LC_X + 8'd1;
                send_char(esd_pkg::CH_BSLASH);
                send_char(esd_pkg::CH_LC_X);
                send_char(c);
            end
        endcase
    endtask

    task automatic random_token();
        repeat ($urandom_range(0, 6)) random_segment();
        send_char(($urandom_range(0, 3) == 0) ? esd_pkg::CH_NUL : rand_blank());
    endtask

    // ---------------- tests ----------------

    task automatic test_plain_bytes();
        send_char(8'hFF);
        send_char(8'h01);
        send_char(esd_pkg::CH_SPACE);
        send_char(esd_pkg::CH_NUL);
    endtask

    task automatic test_escapes();
        send_char(esd_pkg::CH_BSLASH);
        send_char(esd_pkg::CH_LC_A);
        send_char(esd_pkg::CH_BSLASH);
        send_char(esd_pkg::CH_SPACE);
    endtask

    task automatic test_digit_runs();
        send_char(esd_pkg::CH_BSLASH);
        send_char(esd_pkg::CH_ZERO + 8'd3);
        send_char(esd_pkg::CH_SEVEN);
        send_char(esd_pkg::CH_SEVEN);
        send_char(esd_pkg::CH_BSLASH);
        send_char(esd_pkg::CH_ZERO + 8'd4);
        send_char(esd_pkg::CH_ZERO);
        send_char(esd_pkg::CH_ZERO + 8'd1);
        // octal run cut short by a plain character
        send_char(esd_pkg::CH_BSLASH);
        send_char(esd_pkg::CH_SEVEN);
        send_char(8'h7A);
        // hex run cut short by a NUL token end
        send_char(esd_pkg::CH_BSLASH);
        send_char(esd_pkg::CH_LC_X);
        send_char(esd_pkg::CH_UC_F);
        send_char(esd_pkg::CH_NUL);
    endtask

    task automatic test_malformed();
        send_char(esd_pkg::CH_BSLASH);
        send_char(esd_pkg::CH_LC_X);
        send_char(8'h67);
        send_char(esd_pkg::CH_BSLASH);
        send_char(esd_pkg::CH_NUL);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        wait (holding);
        sender_gaps = 1'b0;
        repeat (30) send_char(rand_plain());
        send_char(esd_pkg::CH_SPACE);
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    task automatic test_random();
        int stop_at;
        stop_at = n_sent + RANDOM_ITEMS;
        while (n_sent < stop_at)
            random_token();
    endtask

    // ---------------- result side ----------------

    initial begin : pop_driver
        int gap;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                holding = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding  = 1'b0;
                hold_req = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        esd_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected transaction: kind=%0d byte=%02h len=%0d last=%0b",
                             o_kind, o_out_byte, o_token_length, o_last);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind || o_out_byte !== want.out_byte ||
                    o_token_length !== want.token_length || o_last !== want.last) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("mismatch: expected kind=%0d byte=%02h len=%0d last=%0b",
                                 want.kind, want.out_byte, want.token_length, want.last);
                        $display("          got      kind=%0d byte=%02h len=%0d last=%0b",
                                 o_kind, o_out_byte, o_token_length, o_last);
                    end
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_ch    <= '0;
        dec_len = '0;
        reset_run();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_bytes();
        test_escapes();
        test_digit_runs();
        test_malformed();
        wait_drained();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (n_fail == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
design/esd_pkg.sv
design/esd_front.sv
design/esd_back.sv
design/escape_sequence_decoder.sv
tb/tb_escape_sequence_decoder.sv
